@@ rtl/u8san_pkg.sv @@
// Shared types, constants and byte-classification helpers for the UTF-8 sanitizer.
// No dependencies; imported by u8san_ctrl, u8san_dp and utf8_stream_sanitizer.
`default_nettype none

package u8san_pkg;

    // Replacement character U+FFFD as UTF-8
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // Byte classes
    localparam logic [7:0] TRAIL_MASK = 8'hC0;
    localparam logic [7:0] TRAIL_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;

    // Input command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Work queue depth: held trail bytes plus the new byte
    localparam int QDEPTH = 4;

    // Where an emitted byte comes from
    typedef enum logic [1:0] {
        EMIT_HEAD,  // head of the work queue
        EMIT_REPL,  // replacement character, byte index from controller
        EMIT_HELD,  // held sequence byte, index from controller
        EMIT_CUR    // saved closing byte of a good sequence
    } t_emit_src;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      pop;
        logic      requeue;
        logic      hold_start;
        logic      hold_append;
        logic      clear_held;
        logic      save_cur;
        logic      emit;
        logic      finish;
        t_emit_src emit_src;
        logic [1:0] emit_idx;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       q_empty;
        logic       head_ascii;
        logic       head_lead;
        logic       held_any;
        logic       hold_more;
        logic       seq_ok;
        logic [1:0] held_count;
        logic       can_emit;
        logic       out_free;
        logic       pend_valid;
    } t_dp_status;

    // Full sequence length for a lead byte, zero if not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
        return len;
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b & TRAIL_MASK) == TRAIL_TAG;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/u8san_dp.sv @@
// Datapath of the UTF-8 sanitizer: work queue, held sequence, pending and output words.
// Depends on u8san_pkg; driven by u8san_ctrl through t_dp_cmd.
`default_nettype none

module u8san_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_data_byte,
    input  u8san_pkg::t_dp_cmd    i_cmd,
    output u8san_pkg::t_dp_status o_status,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);
    import u8san_pkg::*;

    // Work queue, shifted toward entry 0
    logic [7:0] r_q [QDEPTH];
    logic [2:0] r_qn;
    // Held sequence
    logic [7:0] r_hb [3];
    logic [1:0] r_cnt;
    logic [2:0] r_len;
    logic [7:0] r_cur;
    // One-word delay so the final word of a step can be marked
    logic       r_pend_v;
    logic [7:0] r_pend_b;
    logic       r_out_v;
    logic [7:0] r_out_b;
    logic       r_out_last;

    logic [7:0] head;
    logic [7:0] emit_byte;
    logic [7:0] rq [QDEPTH];
    logic [2:0] rq_n;
    logic       out_take;

    assign head     = r_q[0];
    assign out_take = r_out_v && i_out_ready;

    // Status toward the controller
    always_comb begin
        o_status.q_empty    = (r_qn == 3'd0);
        o_status.head_ascii = !head[7];
        o_status.head_lead  = (lead_len(head) != 3'd0);
        o_status.held_any   = (r_cnt != 2'd0);
        o_status.hold_more  = ({1'b0, r_cnt} + 3'd1 < r_len) && (r_cnt < 2'd3);
        o_status.seq_ok     = is_trail(head)
                              && (r_cnt < 2'd2 || is_trail(r_hb[1]))
                              && (r_cnt < 2'd3 || is_trail(r_hb[2]));
        o_status.held_count = r_cnt;
        o_status.can_emit   = !r_pend_v || !r_out_v || i_out_ready;
        o_status.out_free   = !r_out_v || i_out_ready;
        o_status.pend_valid = r_pend_v;
    end

    // Emitted byte select
    always_comb begin
        case (i_cmd.emit_src)
            EMIT_HEAD: emit_byte = head;
            EMIT_REPL: emit_byte = repl_byte(i_cmd.emit_idx);
            EMIT_HELD: emit_byte = r_hb[i_cmd.emit_idx];
            default:   emit_byte = r_cur;
        endcase
    end

    // Failed sequence: trail bytes go back in front of the closing byte
    always_comb begin
        rq = r_q;
        case (r_cnt)
            2'd2: begin
                rq[0] = r_hb[1];
                rq[1] = r_q[0];
                rq[2] = r_q[1];
                rq[3] = r_q[2];
            end
            2'd3: begin
                rq[0] = r_hb[1];
                rq[1] = r_hb[2];
                rq[2] = r_q[0];
                rq[3] = r_q[1];
            end
            default: ;
        endcase
        rq_n = r_qn + {1'b0, r_cnt} - 3'd1;
    end

    // Work queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= 3'd0;
        end else if (i_cmd.load) begin
            r_q[0] <= i_data_byte;
            r_qn   <= 3'd1;
        end else if (i_cmd.requeue) begin
            r_q  <= rq;
            r_qn <= rq_n;
        end else if (i_cmd.pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) r_q[i] <= r_q[i + 1];
            r_qn <= r_qn - 3'd1;
        end
    end

    // Held sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= 3'd0;
        end else if (i_cmd.clear_held || i_cmd.requeue) begin
            r_cnt <= 2'd0;
            r_len <= 3'd0;
        end else if (i_cmd.hold_start) begin
            r_hb[0] <= head;
            r_cnt   <= 2'd1;
            r_len   <= lead_len(head);
        end else if (i_cmd.hold_append) begin
            r_hb[r_cnt] <= head;
            r_cnt       <= r_cnt + 2'd1;
        end
        if (i_cmd.save_cur) r_cur <= head;
    end

    // Pending word and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_v    <= 1'b1;
            r_out_b    <= r_pend_b;
            r_out_last <= 1'b1;
            r_pend_v   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend_v <= 1'b1;
            r_pend_b <= emit_byte;
            if (r_pend_v) begin
                r_out_v    <= 1'b1;
                r_out_b    <= r_pend_b;
                r_out_last <= 1'b0;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out_b;
    assign o_last      = r_out_last;

    // Queue never outgrows its storage
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= 3'(QDEPTH))
        else $error("work queue overflow");

    // A held sequence always has a valid length and is not yet complete
    a_held_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> (r_len >= 3'd2 && r_len <= 3'd4 && {1'b0, r_cnt} < r_len))
        else $error("held sequence length inconsistent");

    // A word is never pushed over an output word that is still waiting
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.finish) |-> (!r_pend_v || !r_out_v || i_out_ready))
        else $error("word emitted without room");

    // Finish only moves a real pending word
    a_finish_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_pend_v)
        else $error("finish without pending word");

endmodule

`default_nettype wire

@@ rtl/u8san_ctrl.sv @@
// Controller of the UTF-8 sanitizer: walks the work queue and sequences emitted words.
// Depends on u8san_pkg; drives u8san_dp through t_dp_cmd.
`default_nettype none

module u8san_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_command,
    output logic                  o_in_ready,
    input  u8san_pkg::t_dp_status i_status,
    output u8san_pkg::t_dp_cmd    o_cmd
);
    import u8san_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for an input word
        S_PROC,   // resolve the head of the work queue
        S_REPL,   // emit EF BF BD
        S_SEQ,    // emit a good held sequence
        S_FIN     // push the last word of the step
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd          = '0;
        o_cmd.emit_src = EMIT_HEAD;
        o_cmd.emit_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_FLUSH) begin
                        if (i_status.held_any) begin
                            o_cmd.clear_held = 1'b1;
                            n_idx            = 2'd0;
                            n_state          = S_REPL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_PROC;
                    end
                end
            end
            S_PROC: begin
                if (i_status.q_empty) begin
                    n_state = S_FIN;
                end else if (!i_status.held_any) begin
                    if (i_status.head_ascii) begin
                        if (i_status.can_emit) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.pop  = 1'b1;
                        end
                    end else if (i_status.head_lead) begin
                        o_cmd.hold_start = 1'b1;
                        o_cmd.pop        = 1'b1;
                    end else begin
                        o_cmd.pop = 1'b1;
                        n_idx     = 2'd0;
                        n_state   = S_REPL;
                    end
                end else if (i_status.hold_more) begin
                    o_cmd.hold_append = 1'b1;
                    o_cmd.pop         = 1'b1;
                end else if (i_status.seq_ok) begin
                    o_cmd.save_cur = 1'b1;
                    o_cmd.pop      = 1'b1;
                    n_idx          = 2'd0;
                    n_state        = S_SEQ;
                end else begin
                    // bad trail: drop the lead, rescan the rest
                    o_cmd.requeue = 1'b1;
                    n_idx         = 2'd0;
                    n_state       = S_REPL;
                end
            end
            S_REPL: begin
                o_cmd.emit_src = EMIT_REPL;
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == 2'd2) begin
                        n_idx   = 2'd0;
                        n_state = S_PROC;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_SEQ: begin
                o_cmd.emit_src = (r_idx == i_status.held_count) ? EMIT_CUR : EMIT_HELD;
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == i_status.held_count) begin
                        o_cmd.clear_held = 1'b1;
                        n_idx            = 2'd0;
                        n_state          = S_PROC;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_FIN: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Between steps nothing is left to process or to mark
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> (i_status.q_empty && !i_status.pend_valid))
        else $error("step ended with work left");

    // Sequence emission never runs past the held bytes
    a_seq_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEQ |-> (r_idx <= i_status.held_count && i_status.held_any))
        else $error("sequence index out of range");

    // A data word always lands in the queue
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_command == CMD_DATA) |=> r_state == S_PROC)
        else $error("data word not taken into queue");

endmodule

`default_nettype wire

@@ rtl/utf8_stream_sanitizer.sv @@
// Top level of the UTF-8 sanitizer: joins controller and datapath.
// Depends on u8san_pkg, u8san_ctrl and u8san_dp.
//
//  channel | handshake                 | fields
//  --------+---------------------------+------------------------
//  input   | i_in_valid / o_in_ready   | i_command, i_data_byte
//  output  | o_out_valid / i_out_ready | o_out_byte, o_last
//
// One input word at a time: an ASCII or held byte goes through accept, process, empty
// check and finish; a good sequence is emitted once its last byte arrives, each replacement
// character adds its three bytes, and a flush with nothing held goes straight to finish.
// The controller emits at most one word per cycle; output backpressure stalls it, and
// one pending word plus the output register let work go on while a word waits.
// Reset is synchronous, needs no sweep.
`default_nettype none

module utf8_stream_sanitizer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_command,
    input  wire  [7:0] i_data_byte,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import u8san_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    u8san_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    u8san_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
